// ===== sv/lfps_pkg.sv =====
// Shared types, constants and codes for the line-follow PID steering block.
// No dependencies; every other file of the block imports this package.
package lfps_pkg;

    localparam int ADC_BITS  = 10;
    localparam int THR_BITS  = 10;
    localparam int CMP_W     = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;
    localparam int NUM_LANES = 7;
    localparam int WT_W      = 5;

    typedef logic signed [WT_W-1:0] t_wt;

    // Lane order: outer left, inner left, middle, inner right, outer right,
    // left arm, right arm.
    localparam t_wt LANE_WT [NUM_LANES] = '{
        -5'sd4, -5'sd2, 5'sd0, 5'sd2, 5'sd4, -5'sd6, 5'sd6
    };

    typedef struct packed {
        logic [THR_BITS-1:0] threshold;
        logic [6:0]          gain_p;
        logic [6:0]          gain_i;
        logic [6:0]          gain_d;
        logic [6:0]          integ_lim;
        logic [9:0]          out_lim;
    } t_cfg;

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_GAIN_P    = 3'd1,
        CFG_GAIN_I    = 3'd2,
        CFG_GAIN_D    = 3'd3,
        CFG_INTEG_LIM = 3'd4,
        CFG_OUT_LIM   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_PID
    } t_state;

    localparam logic [THR_BITS-1:0] RST_THRESHOLD = 10'd512;
    localparam logic [6:0]          RST_GAIN_P    = 7'd20;
    localparam logic [6:0]          RST_GAIN_I    = 7'd0;
    localparam logic [6:0]          RST_GAIN_D    = 7'd5;
    localparam logic [6:0]          RST_INTEG_LIM = 7'd10;
    localparam logic [9:0]          RST_OUT_LIM   = 10'd100;

endpackage

// ===== sv/lfps_lane.sv =====
// One sensor lane: threshold compare and weight gating.
// Depends on lfps_pkg.
module lfps_lane
    import lfps_pkg::*;
(
    input  logic [ADC_BITS-1:0] i_sample,
    input  logic [THR_BITS-1:0] i_threshold,
    input  t_wt                 i_weight,
    output logic                o_on,
    output t_wt                 o_wt
);

    always_comb begin
        o_on = (CMP_W'(i_sample) <= CMP_W'(i_threshold));
        o_wt = o_on ? i_weight : '0;
    end

endmodule

// ===== sv/lfps_merge.sv =====
// Merge stage: sums lane weights and counts lanes on the line.
// Depends on lfps_pkg.
module lfps_merge
    import lfps_pkg::*;
(
    input  logic [NUM_LANES-1:0] i_on,
    input  t_wt                  i_wt [NUM_LANES],
    output t_wt                  o_sum,
    output logic [2:0]           o_cnt
);

    always_comb begin
        o_sum = '0;
        o_cnt = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            o_sum = o_sum + i_wt[k];
            o_cnt = o_cnt + {2'b00, i_on[k]};
        end
    end

endmodule

// ===== sv/lfps_div.sv =====
// Restoring divider, one quotient bit per cycle: 4-bit magnitude by 3-bit count.
// Depends on lfps_pkg.
module lfps_div
    import lfps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [3:0] i_dividend,
    input  logic [2:0] i_divisor,
    output logic       o_busy,
    output logic [3:0] o_quot
);

    logic       r_busy;
    logic [1:0] r_step;
    logic [3:0] r_dvd;
    logic [2:0] r_rem;
    logic [2:0] r_dsr;
    logic [3:0] rem_sh;
    logic       ge;
    logic [3:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[3]};
        ge      = (rem_sh >= {1'b0, r_dsr});
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[2:0], ge};
            r_rem <= ge ? rem_sub[2:0] : rem_sh[2:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dvd;

endmodule

// ===== sv/lfps_pid.sv =====
// PID sequencer: integral update, three multiply-accumulates on one shared
// multiplier, then output saturation. Depends on lfps_pkg.
module lfps_pid
    import lfps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [3:0]  i_err,
    input  logic signed [3:0]  i_prev,
    input  logic signed [7:0]  i_integ,
    input  t_cfg               i_cfg,
    output logic               o_busy,
    output logic signed [10:0] o_drive,
    output logic signed [7:0]  o_integ
);

    logic               r_busy;
    logic [2:0]         r_ph;
    logic signed [3:0]  r_e;
    logic signed [4:0]  r_dif;
    logic signed [7:0]  r_int;
    logic signed [16:0] r_acc;
    logic signed [10:0] r_drive;

    logic [6:0]         mul_a;
    logic signed [7:0]  mul_b;
    logic signed [15:0] prod;
    logic signed [8:0]  int_sum;
    logic signed [8:0]  int_lim;
    logic signed [7:0]  int_nx;
    logic signed [16:0] out_lim;
    logic signed [10:0] drive_nx;

    always_comb begin
        case (r_ph)
            3'd1: begin
                mul_a = i_cfg.gain_p;
                mul_b = {{4{r_e[3]}}, r_e};
            end
            3'd2: begin
                mul_a = i_cfg.gain_i;
                mul_b = r_int;
            end
            3'd3: begin
                mul_a = i_cfg.gain_d;
                mul_b = {{3{r_dif[4]}}, r_dif};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = $signed({1'b0, mul_a}) * mul_b;

        int_sum = {r_int[7], r_int} + {{5{r_e[3]}}, r_e};
        int_lim = {2'b00, i_cfg.integ_lim};
        if (int_sum > int_lim) begin
            int_nx = int_lim[7:0];
        end else if (int_sum < -int_lim) begin
            int_nx = 8'(-int_lim);
        end else begin
            int_nx = int_sum[7:0];
        end

        out_lim = {7'b0, i_cfg.out_lim};
        if (r_acc > out_lim) begin
            drive_nx = out_lim[10:0];
        end else if (r_acc < -out_lim) begin
            drive_nx = 11'(-out_lim);
        end else begin
            drive_nx = r_acc[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_ph   <= '0;
        end else if (r_busy) begin
            r_ph <= r_ph + 3'd1;
            if (r_ph == 3'd4) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_e   <= i_err;
            r_dif <= {i_err[3], i_err} - {i_prev[3], i_prev};
            r_int <= i_integ;
        end else if (r_busy) begin
            case (r_ph)
                3'd0: r_int <= int_nx;
                3'd1: r_acc <= {prod[15], prod};
                3'd2: r_acc <= r_acc + {prod[15], prod};
                3'd3: r_acc <= r_acc + {prod[15], prod};
                3'd4: r_drive <= drive_nx;
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_busy  = r_busy;
    assign o_drive = r_drive;
    assign o_integ = r_int;

endmodule

// ===== sv/line_follow_pid_steer.sv =====
// Top level of the line-follow PID steering block.
// Depends on lfps_pkg, lfps_lane, lfps_merge, lfps_div and lfps_pid.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one beat per sensor scan:
//   seven ADC samples, one per sensor. Output channel (o_out_valid /
//   i_out_ready) returns one beat per scan: saturated drive, the position
//   error used and the number of sensors on the line.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one register
//   per beat: index 0 threshold, 1 gain_p, 2 gain_i, 3 gain_d,
//   4 integral_limit, 5 output_limit; other indexes are dropped. Write it
//   only while no scan is in flight.
//   Scans do not overlap: the next input beat is taken only after the
//   previous scan has committed; the four-step divider and the five-phase
//   PID sequencer with its single shared multiplier run in turn.
//   A finished result waits in the output register; the next scan is taken
//   meanwhile and, if the receiver still stalls, holds at the commit point
//   until the output register frees up.
//   Reset (i_rst_n low, synchronous): restore register defaults, clear the
//   last error and the integral, drop any scan in flight.
module line_follow_pid_steer
    import lfps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ADC_BITS-1:0] i_sample_outer_left,
    input  logic [ADC_BITS-1:0] i_sample_inner_left,
    input  logic [ADC_BITS-1:0] i_sample_middle,
    input  logic [ADC_BITS-1:0] i_sample_inner_right,
    input  logic [ADC_BITS-1:0] i_sample_outer_right,
    input  logic [ADC_BITS-1:0] i_sample_left_arm,
    input  logic [ADC_BITS-1:0] i_sample_right_arm,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [10:0]  o_drive,
    output logic signed [3:0]   o_position_error,
    output logic [2:0]          o_sensors_on
);

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;

    logic [ADC_BITS-1:0] r_smp [NUM_LANES];
    logic                r_neg;
    logic [2:0]          r_cnt;
    logic signed [3:0]   r_err;
    logic signed [3:0]   r_last;
    logic signed [7:0]   r_integ;

    logic                r_out_valid;
    logic signed [10:0]  r_out_drive;
    logic signed [3:0]   r_out_err;
    logic [2:0]          r_out_cnt;

    logic                lane_on [NUM_LANES];
    logic [NUM_LANES-1:0] on_vec;
    t_wt                 lane_wt [NUM_LANES];
    t_wt                 sum;
    logic [2:0]          cnt;
    logic [3:0]          sum_mag;

    logic                div_start;
    logic                div_busy;
    logic [3:0]          div_quot;
    logic signed [3:0]   err_nx;

    logic                pid_start;
    logic                pid_busy;
    logic signed [10:0]  pid_drive;
    logic signed [7:0]   pid_integ;

    logic                in_take;
    logic                out_free;
    logic                commit;

    // Always taken; user must make writes land between scans, not enforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.gain_p    <= RST_GAIN_P;
            r_cfg.gain_i    <= RST_GAIN_I;
            r_cfg.gain_d    <= RST_GAIN_D;
            r_cfg.integ_lim <= RST_INTEG_LIM;
            r_cfg.out_lim   <= RST_OUT_LIM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[THR_BITS-1:0];
                CFG_GAIN_P:    r_cfg.gain_p    <= i_cfg_data[6:0];
                CFG_GAIN_I:    r_cfg.gain_i    <= i_cfg_data[6:0];
                CFG_GAIN_D:    r_cfg.gain_d    <= i_cfg_data[6:0];
                CFG_INTEG_LIM: r_cfg.integ_lim <= i_cfg_data[6:0];
                CFG_OUT_LIM:   r_cfg.out_lim   <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Capture the scan on the input beat; lanes work from these copies.
    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_smp[0] <= i_sample_outer_left;
            r_smp[1] <= i_sample_inner_left;
            r_smp[2] <= i_sample_middle;
            r_smp[3] <= i_sample_inner_right;
            r_smp[4] <= i_sample_outer_right;
            r_smp[5] <= i_sample_left_arm;
            r_smp[6] <= i_sample_right_arm;
        end
    end

    // Seven lanes compare in parallel, the merge stage reduces them.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lfps_lane u_lane (
            .i_sample    (r_smp[g]),
            .i_threshold (r_cfg.threshold),
            .i_weight    (LANE_WT[g]),
            .o_on        (lane_on[g]),
            .o_wt        (lane_wt[g])
        );
        assign on_vec[g] = lane_on[g];
    end

    lfps_merge u_merge (
        .i_on  (on_vec),
        .i_wt  (lane_wt),
        .o_sum (sum),
        .o_cnt (cnt)
    );

    // Divide the magnitude, then put the sign back: truncation toward zero.
    assign sum_mag   = sum[WT_W-1] ? 4'(-sum) : sum[3:0];
    assign div_start = (r_state == S_SCAN);

    lfps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (cnt),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg <= sum[WT_W-1];
            r_cnt <= cnt;
        end
    end

    // No sensor on the line: hold the previous error.
    always_comb begin
        if (r_cnt == 3'd0) begin
            err_nx = r_last;
        end else if (r_neg) begin
            err_nx = -$signed(div_quot);
        end else begin
            err_nx = $signed(div_quot);
        end
    end

    assign pid_start = (r_state == S_DIV) && !div_busy;

    lfps_pid u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pid_start),
        .i_err   (err_nx),
        .i_prev  (r_last),
        .i_integ (r_integ),
        .i_cfg   (r_cfg),
        .o_busy  (pid_busy),
        .o_drive (pid_drive),
        .o_integ (pid_integ)
    );

    always_ff @(posedge i_clk) begin
        if (pid_start) begin
            r_err <= err_nx;
        end
    end

    // Commit when the PID is done and the output register can take the beat.
    assign out_free = !r_out_valid || i_out_ready;
    assign commit   = (r_state == S_PID) && !pid_busy && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_take) n_state = S_SCAN;
            S_SCAN:  n_state = S_DIV;
            S_DIV:   if (!div_busy) n_state = S_PID;
            S_PID:   if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Loop state advances only on commit, so a stalled scan changes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_integ <= '0;
        end else if (commit) begin
            r_last  <= r_err;
            r_integ <= pid_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_drive <= pid_drive;
            r_out_err   <= r_err;
            r_out_cnt   <= r_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive          = r_out_drive;
    assign o_position_error = r_out_err;
    assign o_sensors_on     = r_out_cnt;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for line_follow_pid_steer: sends sensor scans and
// register writes, predicts every steering beat and checks it field by field.
// Depends on lfps_pkg and the block's RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat
    localparam int DRAIN_CYCLES   = 40;    // settle time after the final drain
    localparam int HOLD_OFF       = 300;   // long receiver stall
    localparam int MAX_PRINTED    = 40;

    // Register indexes past the map; writes to them must be dropped.
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam t_cfg_idx REG_LIST [6] = '{
        CFG_THRESHOLD, CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_INTEG_LIM, CFG_OUT_LIM
    };

    // Lane weights, same lane order as the ports: outer left, inner left,
    // middle, inner right, outer right, left arm, right arm.
    localparam int LANE_WEIGHT [NUM_LANES] = '{-4, -2, 0, 2, 4, -6, 6};

    // Lane bits for directed masks.
    localparam logic [6:0] LN_OUTER_L = 7'b000_0001;
    localparam logic [6:0] LN_INNER_L = 7'b000_0010;
    localparam logic [6:0] LN_MIDDLE  = 7'b000_0100;
    localparam logic [6:0] LN_INNER_R = 7'b000_1000;
    localparam logic [6:0] LN_OUTER_R = 7'b001_0000;
    localparam logic [6:0] LN_ARM_L   = 7'b010_0000;
    localparam logic [6:0] LN_ARM_R   = 7'b100_0000;

    typedef logic [ADC_BITS-1:0] t_sample;

    typedef struct {
        t_sample lane [NUM_LANES];
    } t_scan;

    typedef struct packed {
        logic signed [10:0] drive;
        logic signed [3:0]  pos_err;
        logic [2:0]         on_cnt;
    } t_steer;

    // ------------------------------------------------------------------
    // Block ports; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [9:0]         i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_sample            scan_lane [NUM_LANES] = '{default: '0};
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [10:0] o_drive;
    logic signed [3:0]  o_position_error;
    logic [2:0]         o_sensors_on;

    line_follow_pid_steer i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_sample_outer_left (scan_lane[0]),
        .i_sample_inner_left (scan_lane[1]),
        .i_sample_middle     (scan_lane[2]),
        .i_sample_inner_right(scan_lane[3]),
        .i_sample_outer_right(scan_lane[4]),
        .i_sample_left_arm   (scan_lane[5]),
        .i_sample_right_arm  (scan_lane[6]),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_drive             (o_drive),
        .o_position_error    (o_position_error),
        .o_sensors_on        (o_sensors_on)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Steering predictor: its own copy of the registers and of the loop
    // state, advanced once per accepted scan.
    // ------------------------------------------------------------------
    logic [9:0] thr_cfg;
    logic [6:0] kp_cfg;
    logic [6:0] ki_cfg;
    logic [6:0] kd_cfg;
    logic [6:0] integ_lim_cfg;
    logic [9:0] drive_lim_cfg;
    int         prev_error;
    int         integ_acc;

    t_steer steer_expect_q [$];

    // Run bookkeeping.
    int n_fail     = 0;
    int n_scans    = 0;
    int n_beats    = 0;
    int n_writes   = 0;
    int n_blind    = 0;  // scans with no sensor on the line
    int n_saturate = 0;  // drives cut at the output limit

    // Idle mix, shared by the sender task and the receiver process.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;  // long stall requested by a test
    int hold_left      = 0;  // owned by the receiver process

    function automatic void steer_defaults();
        thr_cfg       = 10'd512;
        kp_cfg        = 7'd20;
        ki_cfg        = 7'd0;
        kd_cfg        = 7'd5;
        integ_lim_cfg = 7'd10;
        drive_lim_cfg = 10'd100;
        prev_error    = 0;
        integ_acc     = 0;
    endfunction

    // Mirror a register write; gains and the integral limit keep 7 bits.
    function automatic void apply_reg(logic [2:0] idx, logic [9:0] data);
        case (idx)
            CFG_THRESHOLD: thr_cfg       = data;
            CFG_GAIN_P:    kp_cfg        = data[6:0];
            CFG_GAIN_I:    ki_cfg        = data[6:0];
            CFG_GAIN_D:    kd_cfg        = data[6:0];
            CFG_INTEG_LIM: integ_lim_cfg = data[6:0];
            CFG_OUT_LIM:   drive_lim_cfg = data;
            default: ;
        endcase
    endfunction

    function automatic t_steer predict_steer(t_scan s);
        int     wsum;
        int     n_on;
        int     err;
        int     last;
        int     drv;
        int     ilim;
        int     olim;
        t_steer r;
        wsum = 0;
        n_on = 0;
        ilim = int'(integ_lim_cfg);
        olim = int'(drive_lim_cfg);
        for (int k = 0; k < NUM_LANES; k++) begin
            if (s.lane[k] <= thr_cfg) begin
                wsum += LANE_WEIGHT[k];
                n_on++;
            end
        end
        last = prev_error;
        // Integer division truncates toward zero; with no sensor on, hold
        // the previous error so the derivative term vanishes.
        if (n_on != 0) begin
            err = wsum / n_on;
        end else begin
            err = last;
            n_blind++;
        end
        // Add first, then clamp the integral.
        integ_acc = integ_acc + err;
        if (integ_acc > ilim) begin
            integ_acc = ilim;
        end else if (integ_acc < -ilim) begin
            integ_acc = -ilim;
        end
        drv = int'(kp_cfg) * err + int'(ki_cfg) * integ_acc + int'(kd_cfg) * (err - last);
        if (drv > olim) begin
            drv = olim;
            n_saturate++;
        end else if (drv < -olim) begin
            drv = -olim;
            n_saturate++;
        end
        prev_error = err;
        r.drive   = drv[10:0];
        r.pos_err = err[3:0];
        r.on_cnt  = n_on[2:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        n_fail++;
        if (n_fail <= MAX_PRINTED) begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both data channels at the rising edge. Check the
    // output beat against the oldest expectation, then predict the scan
    // taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_steer want;
        t_scan  seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_beats++;
            if (steer_expect_q.size() == 0) begin
                report_mismatch($sformatf("beat with nothing expected, drive %0d", o_drive));
            end else begin
                want = steer_expect_q.pop_front();
                if (o_drive !== want.drive) begin
                    report_mismatch($sformatf("beat %0d drive %0d, want %0d",
                                              n_beats, o_drive, want.drive));
                end
                if (o_position_error !== want.pos_err) begin
                    report_mismatch($sformatf("beat %0d position_error %0d, want %0d",
                                              n_beats, o_position_error, want.pos_err));
                end
                if (o_sensors_on !== want.on_cnt) begin
                    report_mismatch($sformatf("beat %0d sensors_on %0d, want %0d",
                                              n_beats, o_sensors_on, want.on_cnt));
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            seen.lane = scan_lane;
            steer_expect_q.push_back(predict_steer(seen));
            n_scans++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: decide ready at the falling edge. A requested hold-off is
    // counted down here; otherwise stall at the current rate.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no beat moves on any channel for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, steer_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Channel drivers. Inputs change at the falling edge only.
    // ------------------------------------------------------------------

    // Offer one scan, with random idle cycles first; valid stays high into
    // the next scan when no idle cycle falls between them.
    task automatic send_scan(t_scan s);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        scan_lane  = s.lane;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and hold the sender until every expected beat is back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (steer_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic t_scan scan_from_mask(logic [6:0] on_mask, t_sample on_v, t_sample off_v);
        t_scan s;
        for (int k = 0; k < NUM_LANES; k++) begin
            s.lane[k] = on_mask[k] ? on_v : off_v;
        end
        return s;
    endfunction

    // Mostly line-like scans: each lane on or off with a per-scan bias and
    // random level; the rest fully random or pinned to the edges.
    function automatic t_scan random_scan();
        t_scan s;
        int    style;
        int    p_on;
        int    thr;
        style = $urandom_range(9);
        p_on  = $urandom_range(100);
        thr   = int'(thr_cfg);
        for (int k = 0; k < NUM_LANES; k++) begin
            if (style < 6) begin
                if ($urandom_range(99) < p_on || thr == 1023) begin
                    s.lane[k] = t_sample'($urandom_range(thr));
                end else begin
                    s.lane[k] = t_sample'($urandom_range(1023, thr + 1));
                end
            end else if (style < 8) begin
                s.lane[k] = t_sample'($urandom_range(1023));
            end else begin
                case ($urandom_range(3))
                    0: s.lane[k] = '0;
                    1: s.lane[k] = '1;
                    2: s.lane[k] = thr_cfg;
                    default: s.lane[k] = thr_cfg + 10'd1;
                endcase
            end
        end
        return s;
    endfunction

    // Pick extremes half the time; pad 7-bit registers with junk above bit 6.
    function automatic logic [9:0] pick_reg_value(t_cfg_idx idx);
        int top;
        int v;
        top = (idx == CFG_THRESHOLD || idx == CFG_OUT_LIM) ? 1023 : 127;
        case ($urandom_range(3))
            0:       v = 0;
            1:       v = top;
            default: v = $urandom_range(top);
        endcase
        if (top == 127) begin
            v = v | ($urandom_range(7) << 7);
        end
        return v[9:0];
    endfunction

    task automatic random_config();
        foreach (REG_LIST[r]) begin
            write_reg(REG_LIST[r], pick_reg_value(REG_LIST[r]));
        end
        if ($urandom_range(1) == 1) begin
            write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7,
                      10'($urandom_range(1023)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset registers: threshold 512, so 512 is on and 513 is off.
    task automatic test_reset_defaults();
        send_scan(scan_from_mask(7'h00, 10'd0, 10'd1023));      // none on, hold zero
        send_scan(scan_from_mask(7'h7F, 10'd0, 10'd1023));      // all on, sum zero
        send_scan(scan_from_mask(LN_ARM_L, 10'd512, 10'd513));  // hard left
        send_scan(scan_from_mask(LN_ARM_R, 10'd512, 10'd513));  // swing to hard right
        send_scan(scan_from_mask(7'h00, 10'd512, 10'd513));     // lost: keep +6
        send_scan(scan_from_mask(LN_OUTER_L | LN_INNER_L, 10'd512, 10'd513));
        // Uneven averages: -10/3 and +10/3 truncate toward zero.
        send_scan(scan_from_mask(LN_ARM_L | LN_OUTER_L | LN_MIDDLE, 10'd512, 10'd513));
        send_scan(scan_from_mask(LN_ARM_R | LN_OUTER_R | LN_MIDDLE, 10'd512, 10'd513));
        send_scan(scan_from_mask(LN_OUTER_L, 10'd512, 10'd513));
        send_scan(scan_from_mask(LN_INNER_L, 10'd512, 10'd513));
        send_scan(scan_from_mask(LN_MIDDLE, 10'd512, 10'd513));
        send_scan(scan_from_mask(LN_INNER_R, 10'd512, 10'd513));
        send_scan(scan_from_mask(LN_OUTER_R, 10'd512, 10'd513));
        drain_results();
    endtask

    // Full gains and limits, written with junk above the 7-bit fields.
    task automatic test_gain_extremes();
        write_reg(CFG_GAIN_P, 10'h3FF);
        write_reg(CFG_GAIN_I, 10'h3FF);
        write_reg(CFG_GAIN_D, 10'h3FF);
        write_reg(CFG_INTEG_LIM, 10'h3FF);
        write_reg(CFG_OUT_LIM, 10'd1023);
        send_scan(scan_from_mask(LN_ARM_L, 10'd0, 10'd1023));
        send_scan(scan_from_mask(LN_ARM_R, 10'd0, 10'd1023));
        send_scan(scan_from_mask(7'h00, 10'd0, 10'd1023));
        drain_results();
    endtask

    // Zero integral limit pins the sum at zero; zero output limit pins drive.
    task automatic test_zero_limits();
        write_reg(CFG_INTEG_LIM, 10'h380);
        send_scan(scan_from_mask(LN_ARM_L, 10'd0, 10'd1023));
        drain_results();
        write_reg(CFG_OUT_LIM, 10'd0);
        send_scan(scan_from_mask(LN_ARM_R, 10'd0, 10'd1023));
        drain_results();
    endtask

    task automatic test_threshold_extremes();
        write_reg(CFG_OUT_LIM, 10'd1023);
        write_reg(CFG_THRESHOLD, 10'd0);
        send_scan(scan_from_mask(LN_OUTER_L | LN_MIDDLE, 10'd0, 10'd1));
        drain_results();
        write_reg(CFG_THRESHOLD, 10'd1023);
        send_scan(scan_from_mask(7'h00, 10'd0, 10'd1023));      // every lane on
        drain_results();
    endtask

    // Writes past the register map must leave every register alone.
    task automatic test_spare_index();
        write_reg(CFG_SPARE_6, 10'd0);
        write_reg(CFG_SPARE_7, 10'h3FF);
        send_scan(scan_from_mask(LN_INNER_R | LN_OUTER_R, 10'd700, 10'd1000));
        drain_results();
    endtask

    // Random scans under one idle mix; now and then pause until drained and
    // reprogram, so the loop state carries across settings.
    task automatic test_random_mix(int src_pct, int sink_pct, int n_items);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        random_config();
        for (int i = 0; i < n_items; i++) begin
            send_scan(random_scan());
            if ($urandom_range(39) == 0) begin
                drain_results();
                random_config();
            end
        end
        drain_results();
    endtask

    // Hold the receiver off for a long stretch while scans keep coming, so
    // the block fills and stalls its input.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = HOLD_OFF;
        for (int i = 0; i < 16; i++) begin
            send_scan(random_scan());
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial begin
        steer_defaults();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_gain_extremes();
        test_zero_limits();
        test_threshold_extremes();
        test_spare_index();
        test_random_mix(0, 0, 150);
        test_random_mix(68, 0, 150);
        test_random_mix(0, 68, 150);
        test_random_mix(28, 28, 150);
        test_backpressure();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d scans and %0d steering beats across %0d register writes,",
                 n_scans, n_beats, n_writes);
        $display("four idle mixes and a %0d-cycle receiver hold-off; %0d blind scans, %0d %s",
                 HOLD_OFF, n_blind, n_saturate, "saturated drives");
        if (n_fail == 0 && steer_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
